>>> hw/rtl/pfc_pkg.sv
// Shared types, constants and helper functions for the pixel format converter.
// No dependencies; every other file of the block refers to it by scoped names.
package pfc_pkg;

  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int SIZE_W   = 5;
  localparam int BPP_W    = 6;
  localparam int BYTES_W  = 3;
  localparam int CFG_W    = 6;
  localparam int IDX_W    = 3;
  localparam int MASK_W   = 31;
  localparam int NUM_W    = 39;
  localparam int QTAB_W   = 24;
  localparam int X2_W     = 15;
  localparam int RECIP_W  = 16;
  localparam int Y_W      = 31;
  localparam int RECIP_SH = 23;
  localparam int N_STG    = 6;

  // ceil(2^23 / 255); exact for the small remainder products.
  localparam logic [RECIP_W-1:0] RECIP_255 = 16'd32897;

  // Reset values of the format registers (XRGB8888 as the native format).
  localparam logic [BPP_W-1:0]   RST_BPP        = 6'd32;
  localparam logic [BYTES_W-1:0] RST_BYTES      = 3'd4;
  localparam logic [SIZE_W-1:0]  RST_RED_SIZE   = 5'd8;
  localparam logic [SIZE_W-1:0]  RST_RED_POS    = 5'd16;
  localparam logic [SIZE_W-1:0]  RST_GREEN_SIZE = 5'd8;
  localparam logic [SIZE_W-1:0]  RST_GREEN_POS  = 5'd8;
  localparam logic [SIZE_W-1:0]  RST_BLUE_SIZE  = 5'd8;
  localparam logic [SIZE_W-1:0]  RST_BLUE_POS   = 5'd0;

  // floor(2^s / 255) for every channel size s.
  localparam logic [QTAB_W-1:0] QTAB [32] = '{
    24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
    24'd1, 24'd2, 24'd4, 24'd8, 24'd16, 24'd32, 24'd64, 24'd128,
    24'd257, 24'd514, 24'd1028, 24'd2056, 24'd4112, 24'd8224, 24'd16448, 24'd32896,
    24'd65793, 24'd131586, 24'd263172, 24'd526344,
    24'd1052688, 24'd2105376, 24'd4210752, 24'd8421504
  };

  typedef enum logic [IDX_W-1:0] {
    CFG_BPP        = 3'd0,
    CFG_BYTES      = 3'd1,
    CFG_RED_SIZE   = 3'd2,
    CFG_RED_POS    = 3'd3,
    CFG_GREEN_SIZE = 3'd4,
    CFG_GREEN_POS  = 3'd5,
    CFG_BLUE_SIZE  = 3'd6,
    CFG_BLUE_POS   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] pos;
  } chan_cfg_t;

  // Bit k is the valid bit of pipeline stage k+1.
  typedef logic [N_STG-1:0] stg_vld_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [1:0]       qbits;
  } div_res_t;

  function automatic logic [PIX_W-1:0] low_mask(input logic [BPP_W-1:0] nbits);
    logic [PIX_W:0] one_sh;
    one_sh = (PIX_W+1)'(1) << nbits;
    if (nbits >= 6'd32) begin
      return '1;
    end
    return one_sh[PIX_W-1:0] - 32'd1;
  endfunction

  function automatic logic [PIX_W-1:0] byte_mask(input logic [BYTES_W-1:0] nbytes);
    logic [PIX_W-1:0] m;
    case (nbytes)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Two restoring division steps: quotient bits hi and hi-1.
  function automatic div_res_t div_two(input logic [NUM_W-1:0] rem,
                                       input logic [MASK_W-1:0] divisor,
                                       input logic [2:0] hi);
    logic [NUM_W-1:0] d1;
    logic [NUM_W-1:0] d0;
    div_res_t res;
    d1 = {{(NUM_W-MASK_W){1'b0}}, divisor} << hi;
    d0 = {{(NUM_W-MASK_W){1'b0}}, divisor} << (hi - 3'd1);
    res.rem = rem;
    res.qbits = 2'b00;
    if (res.rem >= d1) begin
      res.rem = res.rem - d1;
      res.qbits[1] = 1'b1;
    end
    if (res.rem >= d0) begin
      res.rem = res.rem - d0;
      res.qbits[0] = 1'b1;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/pfc_unpack_lane.sv
// One color channel of the unpack path: field extract and scale to 8 bits.
// Depends on pfc_pkg; six register stages, quotient found two bits per stage.
module pfc_unpack_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfc_pkg::chan_cfg_t          cfg,
  input  logic [pfc_pkg::PIX_W-1:0]   word,
  input  pfc_pkg::stg_vld_t           stg_vld,
  output logic [pfc_pkg::CH_W-1:0]    q
);

  logic [pfc_pkg::PIX_W-1:0]  full_mask;
  logic [pfc_pkg::MASK_W-1:0] mask_w;
  logic [pfc_pkg::PIX_W-1:0]  shifted;
  logic [pfc_pkg::MASK_W-1:0] v_nxt;
  logic [pfc_pkg::MASK_W-1:0] v_r;
  logic [pfc_pkg::NUM_W-1:0]  num_nxt;
  logic [pfc_pkg::NUM_W-1:0]  num_r;
  pfc_pkg::div_res_t          d3_nxt;
  pfc_pkg::div_res_t          d4_nxt;
  pfc_pkg::div_res_t          d5_nxt;
  pfc_pkg::div_res_t          d6_nxt;
  logic [pfc_pkg::NUM_W-1:0]  rem3_r;
  logic [pfc_pkg::NUM_W-1:0]  rem4_r;
  logic [pfc_pkg::NUM_W-1:0]  rem5_r;
  logic [pfc_pkg::NUM_W-1:0]  rem6_r;
  logic [1:0]                 q3_r;
  logic [3:0]                 q4_r;
  logic [5:0]                 q5_r;
  logic [7:0]                 q6_r;

  // The user must change the format registers only while the pipeline is empty;
  // the block does not enforce this. Relying on that, the stages that need them read them directly.
  assign full_mask = pfc_pkg::low_mask({1'b0, cfg.size});
  assign mask_w    = full_mask[pfc_pkg::MASK_W-1:0];
  assign shifted   = word >> cfg.pos;
  assign v_nxt     = shifted[pfc_pkg::MASK_W-1:0] & mask_w;

  // value * 255 as value * 256 - value.
  assign num_nxt = ({{(pfc_pkg::NUM_W-pfc_pkg::MASK_W){1'b0}}, v_r} << 8)
                 - {{(pfc_pkg::NUM_W-pfc_pkg::MASK_W){1'b0}}, v_r};

  assign d3_nxt = pfc_pkg::div_two(num_r,  mask_w, 3'd7);
  assign d4_nxt = pfc_pkg::div_two(rem3_r, mask_w, 3'd5);
  assign d5_nxt = pfc_pkg::div_two(rem4_r, mask_w, 3'd3);
  assign d6_nxt = pfc_pkg::div_two(rem5_r, mask_w, 3'd1);

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    num_r  <= num_nxt;
    rem3_r <= d3_nxt.rem;
    q3_r   <= d3_nxt.qbits;
    rem4_r <= d4_nxt.rem;
    q4_r   <= {q3_r, d4_nxt.qbits};
    rem5_r <= d5_nxt.rem;
    q5_r   <= {q4_r, d5_nxt.qbits};
    rem6_r <= d6_nxt.rem;
    q6_r   <= {q5_r, d6_nxt.qbits};
  end

  // An empty channel has a zero divisor and reads as zero.
  assign q = (cfg.size == '0) ? '0 : q6_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld[5] && cfg.size != '0)
      |-> (rem6_r < {{(pfc_pkg::NUM_W-pfc_pkg::MASK_W){1'b0}}, mask_w}))
    else $error("unpack remainder not below channel mask");

endmodule

>>> hw/rtl/pfc_pack_lane.sv
// One color channel of the pack path: scale an 8-bit value to the field width
// and move it into place. Depends on pfc_pkg; six register stages.
module pfc_pack_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfc_pkg::chan_cfg_t          cfg,
  input  logic [pfc_pkg::CH_W-1:0]    c,
  input  pfc_pkg::stg_vld_t           stg_vld,
  output logic [pfc_pkg::PIX_W-1:0]   field
);

  logic [pfc_pkg::PIX_W-1:0]  full_mask;
  logic [pfc_pkg::PIX_W-1:0]  pos_mask;
  logic [pfc_pkg::MASK_W-1:0] mask_w;
  logic [pfc_pkg::CH_W-1:0]   c_r;
  logic [pfc_pkg::PIX_W-1:0]  p1_nxt;
  logic [pfc_pkg::PIX_W-1:0]  p1_r;
  logic [pfc_pkg::PIX_W-1:0]  p1d_r;
  logic [pfc_pkg::X2_W-1:0]   c_wide;
  logic [pfc_pkg::X2_W-1:0]   x2_nxt;
  logic [pfc_pkg::X2_W-1:0]   x2_r;
  logic [pfc_pkg::Y_W-1:0]    y_nxt;
  logic [pfc_pkg::Y_W-1:0]    y_r;
  logic [pfc_pkg::MASK_W-1:0] q4_nxt;
  logic [pfc_pkg::MASK_W-1:0] q4_r;
  logic [pfc_pkg::PIX_W-1:0]  sh5_nxt;
  logic [pfc_pkg::PIX_W-1:0]  sh5_r;
  logic [pfc_pkg::PIX_W-1:0]  field_r;

  assign full_mask = pfc_pkg::low_mask({1'b0, cfg.size});
  assign pos_mask  = pfc_pkg::low_mask({1'b0, cfg.pos});
  assign mask_w    = full_mask[pfc_pkg::MASK_W-1:0];

  // With 2^s = 255*Q + 2^(s mod 8), c*(2^s-1)/255 splits into c*Q plus a
  // small remainder term c*(2^(s mod 8)-1)/255.
  assign p1_nxt = {{(pfc_pkg::PIX_W-pfc_pkg::CH_W){1'b0}}, c_r}
                * {{(pfc_pkg::PIX_W-pfc_pkg::QTAB_W){1'b0}}, pfc_pkg::QTAB[cfg.size]};
  assign c_wide = {{(pfc_pkg::X2_W-pfc_pkg::CH_W){1'b0}}, c_r};
  assign x2_nxt = (c_wide << cfg.size[2:0]) - c_wide;

  assign y_nxt  = {{(pfc_pkg::Y_W-pfc_pkg::X2_W){1'b0}}, x2_r}
                * {{(pfc_pkg::Y_W-pfc_pkg::RECIP_W){1'b0}}, pfc_pkg::RECIP_255};

  assign q4_nxt = p1d_r[pfc_pkg::MASK_W-1:0]
                + {{(pfc_pkg::MASK_W-pfc_pkg::CH_W){1'b0}},
                   y_r[pfc_pkg::Y_W-1:pfc_pkg::RECIP_SH]};

  // Bits pushed past bit 31 drop out here.
  assign sh5_nxt = {1'b0, q4_r} << cfg.pos;

  always_ff @(posedge clk) begin
    c_r     <= c;
    p1_r    <= p1_nxt;
    x2_r    <= x2_nxt;
    p1d_r   <= p1_r;
    y_r     <= y_nxt;
    q4_r    <= q4_nxt;
    sh5_r   <= sh5_nxt;
    field_r <= sh5_r;
  end

  assign field = field_r;

  a_scaled_within_mask: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld[3] |-> (q4_r <= mask_w))
    else $error("pack scaled value exceeds channel mask");

  a_no_bits_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld[4] |-> ((sh5_r & pos_mask) == '0))
    else $error("pack field has bits below its position");

endmodule

>>> hw/rtl/pixel_format_converter_core.sv
// Top level of the pixel format converter: format registers, valid pipeline
// and output register. Depends on pfc_pkg, pfc_unpack_lane and pfc_pack_lane.
//
// Usage:
//   Input: a beat is taken at each rising edge with start high and busy low.
//   busy never rises, so a new pixel may be offered in every cycle. in_mode
//   low converts the native pixel in in_pixel_in to XRGB8888; high packs
//   red<<16|green<<8|blue into the native format.
//   Output: each result is shown on out_pixel_out for one cycle with
//   out_strobe high. Results leave in input order, one per accepted beat.
//   Pipeline: a beat accepted at an edge passes the lane stages and then the
//   output register before it is shown. Throughput is one pixel per clock.
//   The pipeline depth is set by the unpack divider, which finds the 8-bit scaled
//   value two quotient bits per stage over four stages, after an extract
//   stage and a times-255 stage; the pack path is padded to match.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index.
//   Write only while no beat is in flight (seven cycles after the last one).
//   Reset: rst_n low for one edge empties the pipeline and loads the
//   XRGB8888 format (32 bits, 4 bytes, red at 16, green at 8, blue at 0).
//   The receiver cannot stall; results must be taken as they appear.
module pixel_format_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [pfc_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_strobe,
  output logic [pfc_pkg::PIX_W-1:0]      out_pixel_out,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [pfc_pkg::CFG_W-1:0]      cfg_data
);

  logic [pfc_pkg::BPP_W-1:0]   bpp_r;
  logic [pfc_pkg::BYTES_W-1:0] bytes_r;
  logic [pfc_pkg::SIZE_W-1:0]  red_size_r;
  logic [pfc_pkg::SIZE_W-1:0]  red_pos_r;
  logic [pfc_pkg::SIZE_W-1:0]  green_size_r;
  logic [pfc_pkg::SIZE_W-1:0]  green_pos_r;
  logic [pfc_pkg::SIZE_W-1:0]  blue_size_r;
  logic [pfc_pkg::SIZE_W-1:0]  blue_pos_r;

  pfc_pkg::chan_cfg_t          red_cfg;
  pfc_pkg::chan_cfg_t          green_cfg;
  pfc_pkg::chan_cfg_t          blue_cfg;

  pfc_pkg::stg_vld_t           vld_r;
  pfc_pkg::stg_vld_t           vld_nxt;
  logic [pfc_pkg::N_STG-1:0]   mode_r;
  logic [pfc_pkg::N_STG-1:0]   mode_nxt;
  logic                        accept;

  logic [pfc_pkg::PIX_W-1:0]   native;
  logic [pfc_pkg::CH_W-1:0]    red_q;
  logic [pfc_pkg::CH_W-1:0]    green_q;
  logic [pfc_pkg::CH_W-1:0]    blue_q;
  logic [pfc_pkg::PIX_W-1:0]   red_field;
  logic [pfc_pkg::PIX_W-1:0]   green_field;
  logic [pfc_pkg::PIX_W-1:0]   blue_field;

  logic                        out_strobe_r;
  logic [pfc_pkg::PIX_W-1:0]   out_pixel_nxt;
  logic [pfc_pkg::PIX_W-1:0]   out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= pfc_pkg::RST_BPP;
      bytes_r      <= pfc_pkg::RST_BYTES;
      red_size_r   <= pfc_pkg::RST_RED_SIZE;
      red_pos_r    <= pfc_pkg::RST_RED_POS;
      green_size_r <= pfc_pkg::RST_GREEN_SIZE;
      green_pos_r  <= pfc_pkg::RST_GREEN_POS;
      blue_size_r  <= pfc_pkg::RST_BLUE_SIZE;
      blue_pos_r   <= pfc_pkg::RST_BLUE_POS;
    end else if (cfg_we) begin
      case (cfg_index)
        pfc_pkg::CFG_BPP:        bpp_r        <= cfg_data;
        pfc_pkg::CFG_BYTES:      bytes_r      <= cfg_data[pfc_pkg::BYTES_W-1:0];
        pfc_pkg::CFG_RED_SIZE:   red_size_r   <= cfg_data[pfc_pkg::SIZE_W-1:0];
        pfc_pkg::CFG_RED_POS:    red_pos_r    <= cfg_data[pfc_pkg::SIZE_W-1:0];
        pfc_pkg::CFG_GREEN_SIZE: green_size_r <= cfg_data[pfc_pkg::SIZE_W-1:0];
        pfc_pkg::CFG_GREEN_POS:  green_pos_r  <= cfg_data[pfc_pkg::SIZE_W-1:0];
        pfc_pkg::CFG_BLUE_SIZE:  blue_size_r  <= cfg_data[pfc_pkg::SIZE_W-1:0];
        pfc_pkg::CFG_BLUE_POS:   blue_pos_r   <= cfg_data[pfc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign red_cfg   = '{size: red_size_r,   pos: red_pos_r};
  assign green_cfg = '{size: green_size_r, pos: green_pos_r};
  assign blue_cfg  = '{size: blue_size_r,  pos: blue_pos_r};

  // Every stage advances each cycle, so nothing ever holds the input off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign vld_nxt  = {vld_r[pfc_pkg::N_STG-2:0], accept};
  assign mode_nxt = {mode_r[pfc_pkg::N_STG-2:0], in_mode};

  assign native = in_pixel_in & pfc_pkg::byte_mask(bytes_r) & pfc_pkg::low_mask(bpp_r);

  pfc_unpack_lane u_unpack_red (
    .clk(clk), .rst_n(rst_n), .cfg(red_cfg), .word(native), .stg_vld(vld_r), .q(red_q)
  );
  pfc_unpack_lane u_unpack_green (
    .clk(clk), .rst_n(rst_n), .cfg(green_cfg), .word(native), .stg_vld(vld_r), .q(green_q)
  );
  pfc_unpack_lane u_unpack_blue (
    .clk(clk), .rst_n(rst_n), .cfg(blue_cfg), .word(native), .stg_vld(vld_r), .q(blue_q)
  );

  pfc_pack_lane u_pack_red (
    .clk(clk), .rst_n(rst_n), .cfg(red_cfg), .c(in_pixel_in[23:16]),
    .stg_vld(vld_r), .field(red_field)
  );
  pfc_pack_lane u_pack_green (
    .clk(clk), .rst_n(rst_n), .cfg(green_cfg), .c(in_pixel_in[15:8]),
    .stg_vld(vld_r), .field(green_field)
  );
  pfc_pack_lane u_pack_blue (
    .clk(clk), .rst_n(rst_n), .cfg(blue_cfg), .c(in_pixel_in[7:0]),
    .stg_vld(vld_r), .field(blue_field)
  );

  always_comb begin
    if (mode_r[pfc_pkg::N_STG-1]) begin
      out_pixel_nxt = (red_field | green_field | blue_field) & pfc_pkg::byte_mask(bytes_r);
    end else begin
      out_pixel_nxt = {8'd0, red_q, green_q, blue_q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[pfc_pkg::N_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_pixel_out = out_pixel_r;

  a_strobe_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(start && !busy, 7))
    else $error("result strobe without a beat accepted seven cycles earlier");

endmodule

>>> bench/pixel_format_converter_core_tb.sv
// Testbench for pixel_format_converter_core: random and directed pixels in both
// conversion directions under many native formats, checked against an in-bench
// model held in a small scoreboard class. Depends on pfc_pkg and the core RTL.
`timescale 1ns / 1ps

module pixel_format_converter_core_tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int SEGMENTS     = 30;
  localparam int SEG_PIXELS   = 65;
  localparam int DRAIN_CYCLES = 8;

  class pixel_scoreboard;
    logic [5:0]  bpp;
    logic [2:0]  nbytes;
    logic [4:0]  r_size, r_pos, g_size, g_pos, b_size, b_pos;
    logic [31:0] expected_pixels[$];
    int          mismatches;
    int          checked;

    function new();
      bpp = 6'd32;
      nbytes = 3'd4;
      r_size = 5'd8;
      r_pos = 5'd16;
      g_size = 5'd8;
      g_pos = 5'd8;
      b_size = 5'd8;
      b_pos = 5'd0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(pfc_pkg::cfg_idx_t idx, logic [5:0] val);
      case (idx)
        pfc_pkg::CFG_BPP:        bpp = val;
        pfc_pkg::CFG_BYTES:      nbytes = val[2:0];
        pfc_pkg::CFG_RED_SIZE:   r_size = val[4:0];
        pfc_pkg::CFG_RED_POS:    r_pos = val[4:0];
        pfc_pkg::CFG_GREEN_SIZE: g_size = val[4:0];
        pfc_pkg::CFG_GREEN_POS:  g_pos = val[4:0];
        pfc_pkg::CFG_BLUE_SIZE:  b_size = val[4:0];
        pfc_pkg::CFG_BLUE_POS:   b_pos = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mask_of(int unsigned n);
      logic [32:0] one_sh;
      if (n >= 32) return 32'hFFFF_FFFF;
      one_sh = 33'd1 << n;
      return one_sh[31:0] - 32'd1;
    endfunction

    // Channel value scaled to 8 bits, rounding down.
    function logic [7:0] expand_channel(logic [31:0] word, logic [4:0] size,
                                        logic [4:0] pos);
      logic [31:0] m;
      logic [63:0] v;
      logic [63:0] q;
      m = mask_of(size);
      if (m == 32'd0) return 8'h00;
      v = {32'h0, (word >> pos) & m};
      q = (v * 64'd255) / {32'h0, m};
      return q[7:0];
    endfunction

    // 8-bit channel scaled to the field width and moved into place.
    function logic [31:0] compress_channel(logic [7:0] c8, logic [4:0] size,
                                           logic [4:0] pos);
      logic [63:0] v;
      v = ({56'h0, c8} * {32'h0, mask_of(size)}) / 64'd255;
      v = v << pos;
      return v[31:0];
    endfunction

    function logic [31:0] convert_pixel(logic m, logic [31:0] px);
      logic [31:0] native;
      logic [31:0] native_out;
      int unsigned nb;
      nb = (nbytes > 3'd4) ? 4 : nbytes;
      if (!m) begin
        native = px & mask_of(nb * 8) & mask_of(bpp);
        return {8'h00, expand_channel(native, r_size, r_pos),
                expand_channel(native, g_size, g_pos),
                expand_channel(native, b_size, b_pos)};
      end
      native_out = compress_channel(px[23:16], r_size, r_pos)
                 | compress_channel(px[15:8], g_size, g_pos)
                 | compress_channel(px[7:0], b_size, b_pos);
      return native_out & mask_of(nb * 8);
    endfunction

    function void note_pixel(logic m, logic [31:0] px);
      expected_pixels.push_back(convert_pixel(m, px));
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %08h with nothing outstanding", got);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result %0d: pixel_out expected %08h, got %08h", checked, want, got);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_mode = 1'b0;
  logic [pfc_pkg::PIX_W-1:0]      in_pixel_in = '0;
  logic                           out_strobe;
  logic [pfc_pkg::PIX_W-1:0]      out_pixel_out;
  logic                           cfg_we = 1'b0;
  logic [pfc_pkg::IDX_W-1:0]      cfg_index = pfc_pkg::CFG_BPP;
  logic [pfc_pkg::CFG_W-1:0]      cfg_data = '0;

  pixel_scoreboard board;
  int idle_pct = 0;
  int sent_count = 0;
  int format_count = 0;
  int quiet_cycles = 0;

  pixel_format_converter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_pixel_in(in_pixel_in),
    .out_strobe(out_strobe),
    .out_pixel_out(out_pixel_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_pixel(out_pixel_out);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a beat", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_pixel(input logic m, input logic [31:0] px);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_pixel_in <= $urandom();
      @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_pixel_in <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_pixel(m, px);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(input pfc_pkg::cfg_idx_t idx, input logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Registers change only once the pipeline has emptied.
  task automatic load_format(input logic [5:0] bpp, input logic [5:0] nb,
                             input logic [5:0] rs, input logic [5:0] rp,
                             input logic [5:0] gs, input logic [5:0] gp,
                             input logic [5:0] bs, input logic [5:0] bp);
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(pfc_pkg::CFG_BPP, bpp);
    write_reg(pfc_pkg::CFG_BYTES, nb);
    write_reg(pfc_pkg::CFG_RED_SIZE, rs);
    write_reg(pfc_pkg::CFG_RED_POS, rp);
    write_reg(pfc_pkg::CFG_GREEN_SIZE, gs);
    write_reg(pfc_pkg::CFG_GREEN_POS, gp);
    write_reg(pfc_pkg::CFG_BLUE_SIZE, bs);
    write_reg(pfc_pkg::CFG_BLUE_POS, bp);
    cfg_we <= 1'b0;
    format_count++;
  endtask

  function automatic logic [5:0] pick_of(logic [5:0] a, logic [5:0] b,
                                         logic [5:0] c, logic [5:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_format();
    logic [5:0] bpp, nb, rs, rp, gs, gp, bs, bp;
    case ($urandom_range(0, 3))
      0: begin
        bpp = $urandom_range(0, 63);
        nb = $urandom_range(0, 7);
        rs = $urandom_range(0, 31);
        gs = $urandom_range(0, 31);
        bs = $urandom_range(0, 31);
        rp = $urandom_range(0, 31);
        gp = $urandom_range(0, 31);
        bp = $urandom_range(0, 31);
      end
      1: begin
        nb = $urandom_range(1, 4);
        bpp = nb * 8;
        rs = $urandom_range(0, 16);
        gs = $urandom_range(0, 16);
        bs = $urandom_range(0, 16);
        rp = $urandom_range(0, 31) % bpp;
        gp = $urandom_range(0, 31) % bpp;
        bp = $urandom_range(0, 31) % bpp;
      end
      2: begin
        bpp = pick_of(6'd0, 6'd8, 6'd32, 6'd63);
        nb = pick_of(6'd0, 6'd1, 6'd4, 6'd7);
        rs = pick_of(6'd0, 6'd1, 6'd16, 6'd31);
        gs = pick_of(6'd0, 6'd1, 6'd16, 6'd31);
        bs = pick_of(6'd0, 6'd1, 6'd16, 6'd31);
        rp = pick_of(6'd0, 6'd0, 6'd31, 6'd31);
        gp = pick_of(6'd0, 6'd0, 6'd31, 6'd31);
        bp = pick_of(6'd0, 6'd0, 6'd31, 6'd31);
      end
      default: begin
        // Channels packed back to back from bit zero, as real formats are.
        bs = $urandom_range(1, 8);
        gs = $urandom_range(1, 8);
        rs = $urandom_range(1, 8);
        bp = 6'd0;
        gp = bs;
        rp = bs + gs;
        bpp = ((rs + gs + bs + 6'd7) / 8) * 8;
        nb = bpp / 8;
        if ($urandom_range(0, 1)) begin
          bp = rp;
          rp = 6'd0;
          {rs, bs} = {bs, rs};
        end
      end
    endcase
    load_format(bpp, nb, rs, rp, gs, gp, bs, bp);
  endtask

  initial begin
    board = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset format, XRGB8888; the top byte is dropped when packing.
    send_pixel(1'b0, 32'h0000_0000);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'hFF00_0000);
    send_pixel(1'b1, 32'h00FF_FFFF);
    send_pixel(1'b1, 32'h1234_5678);

    load_format(6'd16, 6'd2, 6'd5, 6'd11, 6'd6, 6'd5, 6'd5, 6'd0);
    send_pixel(1'b0, 32'hFFFF_F81F);
    send_pixel(1'b1, 32'h00FF_8001);
    send_pixel(1'b0, 32'h0000_07E0);

    // Red and blue of width zero, green at the usual maximum width.
    load_format(6'd32, 6'd4, 6'd0, 6'd16, 6'd16, 6'd0, 6'd0, 6'd0);
    send_pixel(1'b0, 32'h0000_FFFF);
    send_pixel(1'b1, 32'h0012_3456);

    // A depth that is not a whole number of bytes.
    load_format(6'd12, 6'd3, 6'd4, 6'd8, 6'd4, 6'd4, 6'd4, 6'd0);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h00FF_FFFF);

    load_format(6'd63, 6'd0, 6'd8, 6'd16, 6'd8, 6'd8, 6'd8, 6'd0);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h00FF_FFFF);

    // Wide overlapping channels, one pushed off the top, byte count above four.
    load_format(6'd63, 6'd7, 6'd31, 6'd1, 6'd31, 6'd31, 6'd31, 6'd0);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b0, 32'h8000_0001);
    send_pixel(1'b1, 32'h00FF_7F01);
    send_pixel(1'b1, 32'h0001_0203);

    load_format(6'd0, 6'd4, 6'd8, 6'd24, 6'd8, 6'd8, 6'd8, 6'd0);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h00FF_FFFF);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < SEGMENTS / 3) ? 9 : (seg < 2 * SEGMENTS / 3) ? 61 : 0;
      random_format();
      repeat (SEG_PIXELS) send_pixel($urandom_range(0, 1), rand_pixel());
    end

    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels in both directions across %0d register settings; %0d checked.",
             sent_count, format_count, board.checked);
    $display("Formats ranged from zero depth and zero bytes to wide overlapping channels.");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_unpack_lane.sv
hw/rtl/pfc_pack_lane.sv
hw/rtl/pixel_format_converter_core.sv
bench/pixel_format_converter_core_tb.sv
